// ===== design/segregated_free_list_bump_allocator_defines.svh =====
// Assertion macros for the run allocator.
`ifndef SEGREGATED_FREE_LIST_BUMP_ALLOCATOR_DEFINES_SVH
`define SEGREGATED_FREE_LIST_BUMP_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SFL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfl assertion failed");

`define SFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfl assertion failed");

`else

`define SFL_ASSERT_SAME(label, ante, cons)

`define SFL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/sfl_pkg.sv =====
// Types and codes shared by the run allocator.
package sfl_pkg;

    localparam int LEN_W    = 7;
    localparam int START_W  = 16;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_RECALL = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_REUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BUMPED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RECALLED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_BADLEN    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND     = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [LEN_W-1:0]   run_length;
        logic [START_W-1:0] run_start;
    } sfl_req_t;

    typedef struct packed {
        logic [START_W-1:0]  granted_start;
        logic [LEN_W-1:0]    granted_length;
        logic [KIND_W-1:0]   granted_kind;
        logic [STATUS_W-1:0] status;
    } sfl_res_t;

endpackage

// ===== design/segregated_free_list_bump_allocator.sv =====
// Top level: run allocator with per-length free stacks and a bump pointer.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+--------------------------------
//  request  | start & !busy              | sfl_req_t  request
//  result   | done (one-cycle strobe)    | sfl_res_t  result
//  config   | cfg_valid & cfg_ready      | cfg_index, cfg_data
//
// An accepted request reads its class fill counter into S_LOOK; done strobes
// as S_LOOK returns to idle, or after S_POP for a reuse pop, which first reads
// the stack memory. busy is high for one cycle, and also through S_POP for a
// pop; a new request can be taken while done is high for the previous one.
// Reset clears the state, done, config registers, bump count and the fill valid bits at once: no sweep.
// The result is not held and cannot be stalled; it is valid only while done is high.
`include "segregated_free_list_bump_allocator_defines.svh"

module segregated_free_list_bump_allocator
    import sfl_pkg::*;
#(
    parameter int MAX_TABLE_SIZE = 64,
    parameter int STACK_DEPTH    = 16,
    parameter int INDEX_BITS     = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  sfl_req_t              request,
    output logic                  done,
    output sfl_res_t              result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CLS_W       = (MAX_TABLE_SIZE > 1) ? $clog2(MAX_TABLE_SIZE) : 1;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STORE_DEPTH = MAX_TABLE_SIZE * STACK_DEPTH;
    localparam int SA_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [START_W-1:0] START_MASK =
        (INDEX_BITS >= START_W) ? {START_W{1'b1}} : START_W'((64'd1 << INDEX_BITS) - 64'd1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0]          state_reg, state_next;
    sfl_req_t            req_reg;
    logic [START_W-1:0]  heap_capacity_reg, heap_base_reg;
    logic [KIND_W-1:0]   heap_kind_reg;
    logic [START_W-1:0]  bump_count_reg, bump_count_next;
    logic                done_reg, done_next;
    sfl_res_t            result_reg, result_next;

    logic                accept;
    logic                in_len_ok, len_ok;
    logic [CLS_W-1:0]    in_cls, cls;
    logic [FILL_W-1:0]   fill;
    logic [IDX_W-1:0]    slot_idx;
    logic [SA_W-1:0]     slot_addr;
    logic [START_W:0]    bump_sum;
    logic                fits;
    logic [START_W-1:0]  bumped_start;

    logic                fill_wr_en;
    logic [FILL_W-1:0]   fill_wr_data;
    logic                stk_rd_en, stk_wr_en;
    logic [INDEX_BITS-1:0] stk_rd_data, stk_wr_data;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign in_len_ok = (request.run_length != '0) &&
                       (32'(request.run_length) <= MAX_TABLE_SIZE);
    assign in_cls    = CLS_W'(request.run_length - 7'd1);
    assign len_ok    = (req_reg.run_length != '0) &&
                       (32'(req_reg.run_length) <= MAX_TABLE_SIZE);
    assign cls       = CLS_W'(req_reg.run_length - 7'd1);

    sfl_fill_mem #(
        .DEPTH  (MAX_TABLE_SIZE),
        .ADDR_W (CLS_W),
        .DATA_W (FILL_W)
    ) u_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_len_ok),
        .rd_addr (in_cls),
        .rd_data (fill),
        .wr_en   (fill_wr_en),
        .wr_addr (cls),
        .wr_data (fill_wr_data)
    );

    sfl_stack_mem #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (SA_W),
        .DATA_W (INDEX_BITS)
    ) u_stack (
        .clk     (clk),
        .rd_en   (stk_rd_en),
        .rd_addr (slot_addr),
        .rd_data (stk_rd_data),
        .wr_en   (stk_wr_en),
        .wr_addr (slot_addr),
        .wr_data (stk_wr_data)
    );

    // pop takes the top entry, push writes just above it
    assign slot_idx  = (req_reg.operation == OP_ALLOC) ? IDX_W'(fill - FILL_W'(1)) : IDX_W'(fill);
    assign slot_addr = SA_W'(32'(cls) * STACK_DEPTH + 32'(slot_idx));

    assign bump_sum     = {1'b0, bump_count_reg} + (START_W + 1)'(req_reg.run_length);
    assign fits         = (bump_sum <= {1'b0, heap_capacity_reg});
    assign bumped_start = (heap_base_reg + bump_count_reg) & START_MASK;
    assign stk_wr_data  = INDEX_BITS'(req_reg.run_start & START_MASK);

    always_comb
    begin
        state_next      = state_reg;
        bump_count_next = bump_count_reg;
        done_next       = 1'b0;
        fill_wr_en      = 1'b0;
        fill_wr_data    = fill;
        stk_rd_en       = 1'b0;
        stk_wr_en       = 1'b0;
        result_next.granted_start  = '0;
        result_next.granted_length = req_reg.run_length;
        result_next.granted_kind   = heap_kind_reg;
        result_next.status         = STAT_BADLEN;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (!len_ok)
                begin
                    result_next.status = STAT_BADLEN;
                end
                else if (req_reg.operation == OP_ALLOC)
                begin
                    if (fill != '0)
                    begin
                        fill_wr_en   = 1'b1;
                        fill_wr_data = fill - FILL_W'(1);
                        stk_rd_en    = 1'b1;
                        done_next    = 1'b0;
                        state_next   = S_POP;
                    end
                    else if (fits)
                    begin
                        bump_count_next            = bump_sum[START_W-1:0];
                        result_next.granted_start  = bumped_start;
                        result_next.status         = STAT_BUMPED;
                    end
                    else
                    begin
                        result_next.status = STAT_EXHAUSTED;
                    end
                end
                else
                begin
                    if (32'(fill) < STACK_DEPTH)
                    begin
                        fill_wr_en         = 1'b1;
                        fill_wr_data       = fill + FILL_W'(1);
                        stk_wr_en          = 1'b1;
                        result_next.status = STAT_RECALLED;
                    end
                    else
                    begin
                        result_next.status = STAT_FULL;
                    end
                end
            end
            S_POP:
            begin
                state_next                = S_IDLE;
                done_next                 = 1'b1;
                result_next.granted_start = START_W'(stk_rd_data);
                result_next.status        = STAT_REUSED;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            done_reg          <= 1'b0;
            bump_count_reg    <= '0;
            heap_capacity_reg <= '0;
            heap_base_reg     <= '0;
            heap_kind_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            bump_count_reg <= bump_count_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CAPACITY: heap_capacity_reg <= cfg_data;
                    CFG_BASE:     heap_base_reg     <= cfg_data;
                    CFG_KIND:     heap_kind_reg     <= cfg_data[KIND_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (done_next)
        begin
            result_reg <= result_next;
        end
    end

    `SFL_ASSERT_NEXT(a_accept_looks, accept, state_reg == S_LOOK)
    `SFL_ASSERT_NEXT(a_pop_answers, state_reg == S_POP, done_reg && result_reg.status == STAT_REUSED)
    `SFL_ASSERT_SAME(a_done_source, done_reg, $past(state_reg) == S_LOOK || $past(state_reg) == S_POP)
    `SFL_ASSERT_SAME(a_bump_moves, done_reg && result_reg.status == STAT_BUMPED, bump_count_reg != $past(bump_count_reg))

endmodule

// ===== design/sfl_fill_mem.sv =====
// Per-class fill counters: synchronous memory with reset-cleared valid bits.
module sfl_fill_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic              hit_reg;
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // never-written class reads as an empty stack
    assign rd_data = hit_reg ? rd_data_reg : '0;

endmodule

// ===== design/sfl_stack_mem.sv =====
// Free stack storage for all length classes, with a registered read.
module sfl_stack_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
